// ===== sv/rrps_pkg.sv =====
// ----------------------------------------------------------------------------
// rrps_pkg
// shared types and constants of the round-robin process scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package rrps_pkg;

	// item function codes
	localparam int unsigned FUNC_W = 2;
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

	// configuration registers
	localparam int unsigned QUANT_W    = 8;
	localparam int unsigned PCOUNT_W   = 7;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PROC_COUNT = 1'b1;
	localparam logic [QUANT_W-1:0]   QUANTUM_RST    = 8'd2;
	localparam logic [PCOUNT_W-1:0]  PCOUNT_RST     = 7'd1;

	// controller to datapath
	typedef struct packed {
		logic clr;        // start item: clear clock, queue and slice
		logic scan_go;    // launch a pass over the participating process slots
		logic scan_push;  // that pass queues slots arriving now
		logic tick_begin; // latch tick start time, clear result
		logic pop;        // read and drop the queue head
		logic cand_rd;    // read remaining of the popped slot
		logic take;       // start a slice for the popped slot
		logic run;        // one tick of execution for the current slot
		logic adv;        // idle tick: advance the clock
		logic wrap;       // end of slice handling and completion time
		logic wait_calc;  // waiting time of a finished process
		logic out_load;   // move the result into the output register
	} rrps_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_idle;
		logic any_rem;
		logic active;
		logic fifo_nonempty;
		logic adv;
	} rrps_sts_t;

endpackage

`default_nettype wire

// ===== sv/rrps_dp.sv =====
// ----------------------------------------------------------------------------
// rrps_dp
// scheduler datapath: slot stores, ready queue, clock, slice and result
// ----------------------------------------------------------------------------
`default_nettype none

module rrps_dp
	import rrps_pkg::*;
#(
	parameter int unsigned MAX_PROCS = 64,
	parameter int unsigned TIME_BITS = 16,
	parameter int unsigned IDX_W     = $clog2(MAX_PROCS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  item_accept,
	input  wire logic [FUNC_W-1:0]     func,
	input  wire logic [IDX_W-1:0]      proc_index,
	input  wire logic [TIME_BITS-1:0]  arrival_time,
	input  wire logic [TIME_BITS-1:0]  burst_time,
	input  wire rrps_cmd_t             cmd,
	output rrps_sts_t                  sts,
	output logic [TIME_BITS-1:0]       tick_time,
	output logic                       running_valid,
	output logic [IDX_W-1:0]           running_proc,
	output logic                       finish_valid,
	output logic [IDX_W-1:0]           finished_proc,
	output logic [TIME_BITS-1:0]       completion_time,
	output logic [TIME_BITS-1:0]       waiting_time,
	output logic [TIME_BITS-1:0]       turnaround_time,
	output logic                       all_done
);

	localparam int unsigned NW = IDX_W + 1;
	localparam logic [NW-1:0]    MAX_N    = NW'(MAX_PROCS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);

	// slot and queue stores
	logic [TIME_BITS-1:0] arrival_mem   [MAX_PROCS];
	logic [TIME_BITS-1:0] burst_mem     [MAX_PROCS];
	logic [TIME_BITS-1:0] remaining_mem [MAX_PROCS];
	logic [IDX_W-1:0]     fifo_mem      [MAX_PROCS];

	logic [QUANT_W-1:0]   quantum_q;
	logic [PCOUNT_W-1:0]  pcount_q;
	logic [TIME_BITS-1:0] clock_q;
	logic                 adv_q;
	logic [IDX_W-1:0]     head_q, tail_q;
	logic [NW-1:0]        count_q;
	logic [IDX_W-1:0]     cur_q;
	logic                 active_q;
	logic [QUANT_W-1:0]   slice_q;
	logic                 end_q, fin_q;

	logic                 scan_busy_q, scan_push_q, any_rem_q;
	logic [NW-1:0]        scan_idx_q;
	logic                 scan_vld_s1;
	logic [IDX_W-1:0]     scan_idx_s1;

	logic [TIME_BITS-1:0] arr_rd_q, burst_rd_q, rem_rd_q;
	logic [IDX_W-1:0]     fifo_rd_q;
	logic [TIME_BITS-1:0] arr_p_q, burst_p_q;

	logic [TIME_BITS-1:0] res_time_q, res_comp_q, res_turn_q, res_wtime_q;
	logic                 res_ran_q, res_fin_q;
	logic [IDX_W-1:0]     res_proc_q, res_fproc_q;

	logic [TIME_BITS-1:0] tick_time_q, completion_q, waiting_q, turnaround_q;
	logic                 running_valid_q, finish_valid_q, all_done_q;
	logic [IDX_W-1:0]     running_proc_q, finished_proc_q;

	logic [NW-1:0]        n_cnt;
	logic                 load_en;
	logic [IDX_W-1:0]     rem_raddr, ab_raddr, rem_waddr;
	logic                 rem_we;
	logic [TIME_BITS-1:0] rem_wdata;
	logic                 scan_hit, wrap_push, push_req, push_en;
	logic [IDX_W-1:0]     push_idx;
	logic [QUANT_W-1:0]   q_eff;
	logic                 clk_max;

	// participating slots, clamped to the store depth
	assign n_cnt = (int'(pcount_q) > int'(MAX_PROCS)) ? MAX_N : NW'(pcount_q);

	assign load_en = item_accept && (func == FUNC_LOAD) && ({1'b0, proc_index} < MAX_N);

	assign rem_raddr = scan_busy_q ? scan_idx_q[IDX_W-1:0] : (cmd.cand_rd ? fifo_rd_q : cur_q);
	assign ab_raddr  = scan_busy_q ? scan_idx_q[IDX_W-1:0] : cur_q;

	assign rem_we    = load_en || cmd.run;
	assign rem_waddr = cmd.run ? cur_q : proc_index;
	assign rem_wdata = cmd.run ? (rem_rd_q - TIME_BITS'(1)) : burst_time;

	assign scan_hit  = scan_vld_s1 && scan_push_q && (rem_rd_q != '0) && (arr_rd_q == clock_q);
	assign wrap_push = cmd.wrap && end_q && !fin_q;
	assign push_req  = scan_hit || wrap_push;
	assign push_en   = push_req && (count_q != MAX_N);
	assign push_idx  = scan_vld_s1 ? scan_idx_s1 : cur_q;

	assign q_eff   = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
	assign clk_max = (clock_q == '1);

	// stores
	always_ff @(posedge clk) begin
		if (load_en) begin
			arrival_mem[proc_index] <= arrival_time;
			burst_mem[proc_index]   <= burst_time;
		end
		arr_rd_q   <= arrival_mem[ab_raddr];
		burst_rd_q <= burst_mem[ab_raddr];
	end

	always_ff @(posedge clk) begin
		if (rem_we) begin
			remaining_mem[rem_waddr] <= rem_wdata;
		end
		rem_rd_q <= remaining_mem[rem_raddr];
	end

	// the popped head is held until the slice decision is made
	always_ff @(posedge clk) begin
		if (push_en) begin
			fifo_mem[tail_q] <= push_idx;
		end
		if (cmd.pop) begin
			fifo_rd_q <= fifo_mem[head_q];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RST;
			pcount_q  <= PCOUNT_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_QUANTUM:    quantum_q <= cfg_data;
				REG_PROC_COUNT: pcount_q  <= cfg_data[PCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// slot scan: one slot per cycle, read data in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_busy_q <= 1'b0;
			scan_push_q <= 1'b0;
			scan_idx_q  <= '0;
			scan_vld_s1 <= 1'b0;
			any_rem_q   <= 1'b0;
		end else begin
			scan_vld_s1 <= scan_busy_q;
			if (cmd.scan_go) begin
				scan_busy_q <= (n_cnt != '0);
				scan_push_q <= cmd.scan_push;
				scan_idx_q  <= '0;
				any_rem_q   <= 1'b0;
			end else begin
				if (scan_busy_q) begin
					scan_idx_q <= scan_idx_q + NW'(1);
					if (scan_idx_q + NW'(1) == n_cnt) begin
						scan_busy_q <= 1'b0;
					end
				end
				if (scan_vld_s1 && (rem_rd_q != '0)) begin
					any_rem_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_idx_q[IDX_W-1:0];
	end

	// ready queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.clr) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.pop && (count_q != '0)) begin
			head_q  <= (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
			count_q <= count_q - NW'(1);
		end else if (push_en) begin
			tail_q  <= (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
			count_q <= count_q + NW'(1);
		end
	end

	// clock, running slot and slice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q  <= '0;
			adv_q    <= 1'b0;
			cur_q    <= '0;
			active_q <= 1'b0;
			slice_q  <= '0;
			end_q    <= 1'b0;
			fin_q    <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clock_q  <= '0;
				cur_q    <= '0;
				active_q <= 1'b0;
				slice_q  <= '0;
			end
			if (cmd.tick_begin) begin
				end_q <= 1'b0;
				fin_q <= 1'b0;
			end
			if (cmd.take && (rem_rd_q != '0)) begin
				cur_q    <= fifo_rd_q;
				active_q <= 1'b1;
				slice_q  <= (rem_rd_q < TIME_BITS'(q_eff)) ? rem_rd_q[QUANT_W-1:0] : q_eff;
			end
			if (cmd.run || cmd.adv) begin
				adv_q <= !clk_max;
				if (!clk_max) begin
					clock_q <= clock_q + TIME_BITS'(1);
				end
			end
			if (cmd.run) begin
				slice_q <= slice_q - QUANT_W'(1);
				end_q   <= (slice_q == QUANT_W'(1)) || (rem_rd_q == TIME_BITS'(1));
				fin_q   <= (rem_rd_q == TIME_BITS'(1));
			end
			if (cmd.wrap && end_q) begin
				active_q <= 1'b0;
				slice_q  <= '0;
			end
		end
	end

	// result of the current tick
	always_ff @(posedge clk) begin
		if (cmd.tick_begin) begin
			res_time_q  <= clock_q;
			res_ran_q   <= 1'b0;
			res_proc_q  <= '0;
			res_fin_q   <= 1'b0;
			res_fproc_q <= '0;
			res_comp_q  <= '0;
			res_turn_q  <= '0;
			res_wtime_q <= '0;
		end
		if (cmd.run) begin
			res_ran_q  <= 1'b1;
			res_proc_q <= cur_q;
			arr_p_q    <= arr_rd_q;
			burst_p_q  <= burst_rd_q;
		end
		if (cmd.wrap && end_q && fin_q) begin
			res_fin_q   <= 1'b1;
			res_fproc_q <= cur_q;
			res_comp_q  <= clock_q;
			res_turn_q  <= (clock_q > arr_p_q) ? clock_q - arr_p_q : '0;
		end
		if (cmd.wait_calc) begin
			res_wtime_q <= (res_turn_q > burst_p_q) ? res_turn_q - burst_p_q : '0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			tick_time_q     <= res_time_q;
			running_valid_q <= res_ran_q;
			running_proc_q  <= res_proc_q;
			finish_valid_q  <= res_fin_q;
			finished_proc_q <= res_fproc_q;
			completion_q    <= res_comp_q;
			waiting_q       <= res_wtime_q;
			turnaround_q    <= res_turn_q;
			all_done_q      <= !any_rem_q;
		end
	end

	assign tick_time       = tick_time_q;
	assign running_valid   = running_valid_q;
	assign running_proc    = running_proc_q;
	assign finish_valid    = finish_valid_q;
	assign finished_proc   = finished_proc_q;
	assign completion_time = completion_q;
	assign waiting_time    = waiting_q;
	assign turnaround_time = turnaround_q;
	assign all_done        = all_done_q;

	assign sts.scan_idle     = !scan_busy_q && !scan_vld_s1;
	assign sts.any_rem       = any_rem_q;
	assign sts.active        = active_q;
	assign sts.fifo_nonempty = (count_q != '0);
	assign sts.adv           = adv_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_N)
		else $error("ready queue count above depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty ready queue with unequal pointers");

	a_idle_slice: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (slice_q == '0))
		else $error("slice left while no process runs");

endmodule

`default_nettype wire

// ===== sv/rrps_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrps_ctrl
// scheduler sequencer: walks start and tick items through the datapath steps
// ----------------------------------------------------------------------------
`default_nettype none

module rrps_ctrl
	import rrps_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic [FUNC_W-1:0] func,
	output logic                   item_stall,
	output logic                   result_valid,
	input  wire logic              result_stall,
	input  wire rrps_sts_t         sts,
	output rrps_cmd_t              cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_ARR_GO,
		S_ARR_WAIT,
		S_PRE_GO,
		S_PRE_WAIT,
		S_POP,
		S_CAND_RD,
		S_TAKE,
		S_CHECK,
		S_RUN_RD,
		S_RUN,
		S_ADV,
		S_POST_GO,
		S_POST_WAIT,
		S_WRAP,
		S_WAIT_CALC,
		S_RESULT
	} state_t;

	state_t state_q, state_d;
	logic   item_stall_q, result_valid_q;
	logic   item_accept, out_free;

	assign item_accept = item_valid && !item_stall_q;
	assign out_free    = !result_valid_q || !result_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_accept) begin
					if (func == FUNC_START) begin
						state_d = S_CLR;
					end else if (func == FUNC_TICK) begin
						state_d = S_PRE_GO;
					end
				end
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				state_d = S_ARR_GO;
			end
			S_ARR_GO: begin
				cmd.scan_go   = 1'b1;
				cmd.scan_push = 1'b1;
				state_d       = S_ARR_WAIT;
			end
			S_ARR_WAIT: begin
				if (sts.scan_idle) begin
					state_d = S_IDLE;
				end
			end
			S_PRE_GO: begin
				cmd.tick_begin = 1'b1;
				cmd.scan_go    = 1'b1;
				state_d        = S_PRE_WAIT;
			end
			S_PRE_WAIT: begin
				if (sts.scan_idle) begin
					priority if (!sts.any_rem) begin
						state_d = S_RESULT;
					end else if (sts.active) begin
						state_d = S_RUN_RD;
					end else if (sts.fifo_nonempty) begin
						state_d = S_POP;
					end else begin
						state_d = S_ADV;
					end
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_CAND_RD;
			end
			S_CAND_RD: begin
				cmd.cand_rd = 1'b1;
				state_d     = S_TAKE;
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				state_d = sts.active ? S_RUN_RD : S_ADV;
			end
			S_RUN_RD: begin
				state_d = S_RUN;
			end
			S_RUN: begin
				cmd.run = 1'b1;
				state_d = S_POST_GO;
			end
			S_ADV: begin
				cmd.adv = 1'b1;
				state_d = S_POST_GO;
			end
			S_POST_GO: begin
				cmd.scan_go   = 1'b1;
				cmd.scan_push = sts.adv;
				state_d       = S_POST_WAIT;
			end
			S_POST_WAIT: begin
				if (sts.scan_idle) begin
					state_d = S_WRAP;
				end
			end
			S_WRAP: begin
				cmd.wrap = 1'b1;
				state_d  = S_WAIT_CALC;
			end
			S_WAIT_CALC: begin
				cmd.wait_calc = 1'b1;
				state_d       = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			item_stall_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			item_stall_q <= (state_d != S_IDLE);
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign item_stall   = item_stall_q;
	assign result_valid = result_valid_q;

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		item_accept |-> sts.scan_idle)
		else $error("transaction accepted during a slot scan");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> sts.fifo_nonempty)
		else $error("pop from an empty ready queue");

	a_take_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> $past(cmd.cand_rd))
		else $error("slice started without candidate read");

endmodule

`default_nettype wire

// ===== sv/round_robin_process_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_process_scheduler
// round-robin process scheduler stepped at most one time unit per tick transaction
// ----------------------------------------------------------------------------
// Load transactions (func 0) write a slot's arrival and burst at the accepting
// edge. A start transaction (func 1) clears the clock and the ready queue and
// then walks the participating slots once, one slot per cycle, queueing those
// arriving at time zero. A tick transaction (func 2) walks the slots twice,
// once to see whether any work remains and once after the clock moves to
// queue new arrivals and recount the remaining work, with a few sequencer
// steps around the walks; when no work is left it walks them only once. The
// walks go slot by slot because the slot stores have a single read port.
// Every tick gives exactly one result transaction; load and start give none.
// The result sits in an output register, so a new transaction is taken while
// a result still waits. Slot stores and the ready-queue entries are not
// cleared by reset (only the queue pointers are) and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_process_scheduler
	import rrps_pkg::*;
#(
	parameter int unsigned MAX_PROCS = 64,
	parameter int unsigned TIME_BITS = 16,
	parameter int unsigned IDX_W     = $clog2(MAX_PROCS)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration writes
	input  wire logic                  cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// item channel
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic [FUNC_W-1:0]     func,
	input  wire logic [IDX_W-1:0]      proc_index,
	input  wire logic [TIME_BITS-1:0]  arrival_time,
	input  wire logic [TIME_BITS-1:0]  burst_time,
	// result channel
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic [TIME_BITS-1:0]       tick_time,
	output logic                       running_valid,
	output logic [IDX_W-1:0]           running_proc,
	output logic                       finish_valid,
	output logic [IDX_W-1:0]           finished_proc,
	output logic [TIME_BITS-1:0]       completion_time,
	output logic [TIME_BITS-1:0]       waiting_time,
	output logic [TIME_BITS-1:0]       turnaround_time,
	output logic                       all_done
);

	rrps_cmd_t cmd;
	rrps_sts_t sts;
	logic      item_accept;

	// loads are written into the slot stores at the accepting edge
	assign item_accept = item_valid && !item_stall;

	// sequencer: one state per datapath step of start and tick
	rrps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.func         (func),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// stores, ready queue, clock, slice counter and output register
	rrps_dp #(
		.MAX_PROCS (MAX_PROCS),
		.TIME_BITS (TIME_BITS),
		.IDX_W     (IDX_W)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.item_accept     (item_accept),
		.func            (func),
		.proc_index      (proc_index),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.cmd             (cmd),
		.sts             (sts),
		.tick_time       (tick_time),
		.running_valid   (running_valid),
		.running_proc    (running_proc),
		.finish_valid    (finish_valid),
		.finished_proc   (finished_proc),
		.completion_time (completion_time),
		.waiting_time    (waiting_time),
		.turnaround_time (turnaround_time),
		.all_done        (all_done)
	);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the round-robin process scheduler
// ----------------------------------------------------------------------------
// A queue of pending steps (item transactions, register writes and sync
// points) is built at time zero. It opens with a directed part and then
// follows with random scheduling phases: load a set of slots, start, then
// tick until the set should be worked off, with reloads, restarts and
// unknown functions mixed in. A clocked driver feeds the item channel and
// runs a scheduler model on every accepted transaction. A clocked monitor
// compares every result transaction with the oldest predicted tick. Both
// sides idle in short random bursts; the receiver holds off once for a long
// stretch so the block backs up into its input.
// ----------------------------------------------------------------------------

module tb;
	import rrps_pkg::*;

	localparam int unsigned SLOTS          = 64;
	localparam int unsigned TW             = 16;
	localparam int unsigned RANDOM_ITEMS   = 1550;
	// a tick walks the slots at most twice; generous margin for loads and starts
	localparam int unsigned SETTLE_CYCLES  = 200;
	localparam int unsigned QUIET_LEFT     = 150;
	localparam int unsigned HOLD_AT        = 200;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

	typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_SYNC} step_kind_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [5:0]        slot;
		logic [TW-1:0]     arrival;
		logic [TW-1:0]     burst;
	} sched_item_t;

	typedef struct packed {
		logic [TW-1:0] tick_time;
		logic          running_valid;
		logic [5:0]    running_proc;
		logic          finish_valid;
		logic [5:0]    finished_proc;
		logic [TW-1:0] completion_time;
		logic [TW-1:0] waiting_time;
		logic [TW-1:0] turnaround_time;
		logic          all_done;
	} sched_result_t;

	typedef struct {
		step_kind_t             kind;
		sched_item_t            item;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [CFG_DATA_W-1:0]  reg_val;
	} step_t;

	// block ports
	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic [FUNC_W-1:0]     func = '0;
	logic [5:0]            proc_index = '0;
	logic [TW-1:0]         arrival_time = '0;
	logic [TW-1:0]         burst_time = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [TW-1:0]         tick_time;
	logic                  running_valid;
	logic [5:0]            running_proc;
	logic                  finish_valid;
	logic [5:0]            finished_proc;
	logic [TW-1:0]         completion_time;
	logic [TW-1:0]         waiting_time;
	logic [TW-1:0]         turnaround_time;
	logic                  all_done;

	// stimulus and scoreboard
	step_t         pending_steps[$];
	sched_result_t expected_ticks[$];
	sched_item_t   cur_item;
	int unsigned   ticks_predicted = 0;
	int unsigned   ticks_checked = 0;
	int unsigned   n_errors = 0;
	int unsigned   gap_left = 0;
	int unsigned   settle_left = 0;
	logic          syncing = 1'b0;
	logic          stim_done = 1'b0;
	logic          quiet = 1'b0;
	int unsigned   stall_left = 0;
	int unsigned   hold_left = 0;
	logic          hold_done = 1'b0;
	int unsigned   idle_cycles = 0;

	// scheduler model state
	logic [TW-1:0] s_arrival[SLOTS];
	logic [TW-1:0] s_burst[SLOTS];
	logic [TW-1:0] s_remain[SLOTS];
	logic [5:0]    ready_ring[SLOTS];
	int unsigned   rq_head, rq_tail, rq_count;
	logic [5:0]    run_slot;
	logic          run_live;
	int unsigned   slice_cnt;
	int unsigned   now_t;
	logic [7:0]    quantum_r;
	logic [6:0]    pcount_r;

	round_robin_process_scheduler dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.func            (func),
		.proc_index      (proc_index),
		.arrival_time    (arrival_time),
		.burst_time      (burst_time),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.tick_time       (tick_time),
		.running_valid   (running_valid),
		.running_proc    (running_proc),
		.finish_valid    (finish_valid),
		.finished_proc   (finished_proc),
		.completion_time (completion_time),
		.waiting_time    (waiting_time),
		.turnaround_time (turnaround_time),
		.all_done        (all_done)
	);

	// ------------------------------------------------------------------
	// scheduler model
	// ------------------------------------------------------------------

	// slots taking part, count clamped to the number of slots
	function automatic int unsigned live_slots();
		return (pcount_r > SLOTS) ? SLOTS : pcount_r;
	endfunction

	// a push onto a full ready queue is dropped
	function automatic void ready_push(logic [5:0] p);
		if (rq_count >= SLOTS)
			return;
		ready_ring[rq_tail] = p;
		rq_tail = (rq_tail + 1) % SLOTS;
		rq_count++;
	endfunction

	// queue slots arriving now, in index order
	function automatic void queue_arrivals();
		for (int i = 0; i < live_slots(); i++)
			if (s_arrival[i] == now_t && s_remain[i] != 0)
				ready_push(i[5:0]);
	endfunction

	function automatic logic no_work();
		for (int i = 0; i < live_slots(); i++)
			if (s_remain[i] != 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// clock stops at its maximum; new arrivals only when it moved
	function automatic void clock_step();
		if (now_t >= (1 << TW) - 1)
			return;
		now_t++;
		queue_arrivals();
	endfunction

	function automatic void sched_reset();
		for (int i = 0; i < SLOTS; i++) begin
			s_arrival[i] = '0;
			s_burst[i] = '0;
			s_remain[i] = '0;
			ready_ring[i] = '0;
		end
		rq_head = 0;
		rq_tail = 0;
		rq_count = 0;
		run_slot = '0;
		run_live = 1'b0;
		slice_cnt = 0;
		now_t = 0;
		quantum_r = QUANTUM_RST;
		pcount_r = PCOUNT_RST;
	endfunction

	function automatic void sched_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		if (idx == REG_QUANTUM)
			quantum_r = val[QUANT_W-1:0];
		else if (idx == REG_PROC_COUNT)
			pcount_r = val[PCOUNT_W-1:0];
	endfunction

	// apply one accepted transaction; a tick leaves one expected result
	function automatic void schedule_item(sched_item_t it);
		sched_result_t r;
		logic [5:0]    cand;
		int unsigned   q;
		int unsigned   turn;
		case (it.func)
			FUNC_LOAD: begin
				s_arrival[it.slot] = it.arrival;
				s_burst[it.slot] = it.burst;
				s_remain[it.slot] = it.burst;
			end
			FUNC_START: begin
				now_t = 0;
				rq_head = 0;
				rq_tail = 0;
				rq_count = 0;
				run_slot = '0;
				run_live = 1'b0;
				slice_cnt = 0;
				queue_arrivals();
			end
			FUNC_TICK: begin
				r = '0;
				r.tick_time = now_t[TW-1:0];
				if (!no_work()) begin
					if (!run_live && rq_count > 0) begin
						cand = ready_ring[rq_head];
						q = (quantum_r == 0) ? 1 : quantum_r;
						rq_head = (rq_head + 1) % SLOTS;
						rq_count--;
						// a slot reloaded to zero while queued is dropped
						if (s_remain[cand] != 0) begin
							run_slot = cand;
							run_live = 1'b1;
							slice_cnt = (s_remain[cand] < q) ? s_remain[cand] : q;
						end
					end
					if (run_live) begin
						r.running_valid = 1'b1;
						r.running_proc = run_slot;
						s_remain[run_slot] = s_remain[run_slot] - 1'b1;
						slice_cnt--;
						clock_step();
						if (slice_cnt == 0 || s_remain[run_slot] == 0) begin
							run_live = 1'b0;
							slice_cnt = 0;
							if (s_remain[run_slot] != 0) begin
								ready_push(run_slot);
							end else begin
								r.finish_valid = 1'b1;
								r.finished_proc = run_slot;
								r.completion_time = now_t[TW-1:0];
								turn = (now_t > s_arrival[run_slot]) ?
									now_t - s_arrival[run_slot] : 0;
								r.turnaround_time = turn[TW-1:0];
								r.waiting_time = (turn > s_burst[run_slot]) ?
									TW'(turn - s_burst[run_slot]) : '0;
							end
						end
					end else begin
						clock_step();
					end
				end
				r.all_done = no_work();
				expected_ticks.push_back(r);
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// step queue builders
	// ------------------------------------------------------------------

	function automatic void push_item(logic [FUNC_W-1:0] f, int unsigned slot,
			int unsigned arr, int unsigned bur);
		step_t st;
		st.kind = STEP_ITEM;
		st.item.func = f;
		st.item.slot = slot[5:0];
		st.item.arrival = arr[TW-1:0];
		st.item.burst = bur[TW-1:0];
		st.reg_idx = '0;
		st.reg_val = '0;
		pending_steps.push_back(st);
	endfunction

	function automatic void push_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		step_t st;
		st.kind = STEP_CFG;
		st.item = '0;
		st.reg_idx = idx;
		st.reg_val = val[CFG_DATA_W-1:0];
		pending_steps.push_back(st);
	endfunction

	// sender waits until every tick result is in, then lets the block settle
	function automatic void push_sync();
		step_t st;
		st.kind = STEP_SYNC;
		st.item = '0;
		st.reg_idx = '0;
		st.reg_val = '0;
		pending_steps.push_back(st);
	endfunction

	// ------------------------------------------------------------------
	// clock, reset and stimulus
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin : build_steps
		int unsigned n_items;
		int unsigned pcnt;
		int unsigned qv;
		int unsigned work;
		int unsigned last_arr;
		int unsigned n_ticks;
		int unsigned a;
		int unsigned b;
		int unsigned r;

		sched_reset();

		// every slot gets written first so no tick ever reads an empty one;
		// zero bursts count as complete straight away
		for (int i = 0; i < SLOTS; i++)
			push_item(FUNC_LOAD, i, 0, 0);

		// reset settings: nothing left, tick is idle and the clock holds
		push_item(FUNC_TICK, 0, 0, 0);
		push_item(FUNC_NONE, 63, 16'hffff, 16'hffff);
		push_item(FUNC_START, 0, 0, 0);
		push_item(FUNC_TICK, 0, 0, 0);

		// unit quantum; stale queue entry; finish before the new arrival
		push_sync();
		push_cfg(REG_QUANTUM, 1);
		push_cfg(REG_PROC_COUNT, 3);
		push_item(FUNC_LOAD, 0, 0, 2);
		push_item(FUNC_LOAD, 1, 0, 3);
		push_item(FUNC_LOAD, 2, 16'hffff, 16'hffff);
		push_item(FUNC_START, 0, 0, 0);
		push_item(FUNC_LOAD, 1, 0, 0);
		push_item(FUNC_LOAD, 0, 9, 2);
		repeat (5) push_item(FUNC_TICK, 0, 0, 0);

		// zero quantum acts as one, oversized process count is clamped
		push_sync();
		push_cfg(REG_QUANTUM, 0);
		push_cfg(REG_PROC_COUNT, 100);
		push_item(FUNC_LOAD, 62, 0, 1);
		push_item(FUNC_LOAD, 63, 0, 3);
		push_item(FUNC_START, 0, 0, 0);
		repeat (4) push_item(FUNC_TICK, 0, 0, 0);

		// widest quantum, no process taking part
		push_sync();
		push_cfg(REG_QUANTUM, 255);
		push_cfg(REG_PROC_COUNT, 0);
		repeat (2) push_item(FUNC_TICK, 0, 0, 0);

		// random phases: load a set, start, tick it through
		n_items = 0;
		while (n_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				pcnt = SLOTS;
			else if (r < 4)
				pcnt = $urandom_range(9, 32);
			else
				pcnt = $urandom_range(1, 8);
			r = $urandom_range(0, 9);
			if (r == 0)
				qv = 255;
			else if (r == 1)
				qv = 1;
			else if (r == 2)
				qv = $urandom_range(1, 255);
			else
				qv = $urandom_range(1, 5);
			push_sync();
			push_cfg(REG_QUANTUM, qv);
			push_cfg(REG_PROC_COUNT, pcnt);

			work = 0;
			last_arr = 0;
			for (int i = 0; i < pcnt; i++) begin
				a = $urandom_range(0, 12);
				b = $urandom_range(0, 6);
				// now and then a slot that never arrives or never ends
				if ($urandom_range(0, 15) == 0)
					a = $urandom_range(0, 16'hffff);
				if ($urandom_range(0, 15) == 0)
					b = $urandom_range(0, 16'hffff);
				push_item(FUNC_LOAD, i, a, b);
				n_items++;
				work += (b > 12) ? 12 : b;
				if (a <= 12 && a > last_arr)
					last_arr = a;
			end
			// slots outside the set take any value
			if (pcnt < SLOTS) begin
				repeat ($urandom_range(0, 2)) begin
					push_item(FUNC_LOAD, $urandom_range(pcnt, SLOTS - 1),
						$urandom_range(0, 16'hffff), $urandom_range(0, 16'hffff));
					n_items++;
				end
			end
			// a few phases skip the start and tick on from the old state
			if ($urandom_range(0, 7) != 0) begin
				push_item(FUNC_START, 0, 0, 0);
				n_items++;
			end

			n_ticks = work + last_arr + $urandom_range(1, 4);
			if (n_ticks > 160)
				n_ticks = 160;
			repeat (n_ticks) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					push_item(FUNC_LOAD, $urandom_range(0, pcnt - 1),
						$urandom_range(0, 12), $urandom_range(0, 4));
					n_items++;
				end else if (r < 6) begin
					push_item(FUNC_NONE, $urandom_range(0, SLOTS - 1),
						$urandom_range(0, 16'hffff), $urandom_range(0, 16'hffff));
				end else if (r < 7) begin
					push_item(FUNC_START, 0, 0, 0);
					n_items++;
				end
				push_item(FUNC_TICK, 0, 0, 0);
				n_items++;
			end
		end
	end

	// ------------------------------------------------------------------
	// driver: item transactions, register writes, sync points
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : driver
		step_t st;
		logic  nx_valid;
		logic  nx_we;
		if (!arst_n) begin
			item_valid <= 1'b0;
			cfg_write_en <= 1'b0;
			gap_left <= 0;
			settle_left <= 0;
			syncing <= 1'b0;
			stim_done <= 1'b0;
			quiet <= 1'b0;
			ticks_predicted <= 0;
		end else begin
			nx_valid = item_valid;
			nx_we = 1'b0;
			// transaction taken at this edge: update the model
			if (item_valid && !item_stall) begin
				schedule_item(cur_item);
				if (cur_item.func == FUNC_TICK)
					ticks_predicted <= ticks_predicted + 1;
				nx_valid = 1'b0;
			end
			// a held payload stays put; choose the next step only when free
			if (!nx_valid) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (syncing) begin
					// every result in, then the block's own latency
					if (ticks_checked == ticks_predicted) begin
						if (settle_left > 0)
							settle_left <= settle_left - 1;
						else
							syncing <= 1'b0;
					end
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					gap_left <= $urandom_range(0, 6);
				end else if (pending_steps.size() == 0) begin
					stim_done <= 1'b1;
				end else begin
					st = pending_steps.pop_front();
					case (st.kind)
						STEP_ITEM: begin
							nx_valid = 1'b1;
							cur_item <= st.item;
							func <= st.item.func;
							proc_index <= st.item.slot;
							arrival_time <= st.item.arrival;
							burst_time <= st.item.burst;
						end
						STEP_CFG: begin
							nx_we = 1'b1;
							cfg_index <= st.reg_idx;
							cfg_data <= st.reg_val;
							sched_config(st.reg_idx, st.reg_val);
						end
						default: begin
							syncing <= 1'b1;
							settle_left <= SETTLE_CYCLES;
						end
					endcase
				end
			end
			item_valid <= nx_valid;
			cfg_write_en <= nx_we;
			// no idling on either side in the last stretch
			quiet <= (pending_steps.size() < QUIET_LEFT);
		end
	end

	// ------------------------------------------------------------------
	// monitor: result transactions and receiver stalls
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : monitor
		sched_result_t want;
		int unsigned   bad;
		logic          nx_stall;
		if (!arst_n) begin
			result_stall <= 1'b0;
			ticks_checked <= 0;
			n_errors <= 0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			bad = 0;
			if (result_valid && !result_stall) begin
				if (expected_ticks.size() == 0) begin
					$error("result transaction with no tick waiting");
					bad++;
				end else begin
					want = expected_ticks.pop_front();
					ticks_checked <= ticks_checked + 1;
					if (want.tick_time !== tick_time) begin
						$error("tick_time: expected %0d, got %0d",
							want.tick_time, tick_time);
						bad++;
					end
					if (want.running_valid !== running_valid) begin
						$error("running_valid: expected %0d, got %0d",
							want.running_valid, running_valid);
						bad++;
					end
					if (want.running_proc !== running_proc) begin
						$error("running_proc: expected %0d, got %0d",
							want.running_proc, running_proc);
						bad++;
					end
					if (want.finish_valid !== finish_valid) begin
						$error("finish_valid: expected %0d, got %0d",
							want.finish_valid, finish_valid);
						bad++;
					end
					if (want.finished_proc !== finished_proc) begin
						$error("finished_proc: expected %0d, got %0d",
							want.finished_proc, finished_proc);
						bad++;
					end
					if (want.completion_time !== completion_time) begin
						$error("completion_time: expected %0d, got %0d",
							want.completion_time, completion_time);
						bad++;
					end
					if (want.waiting_time !== waiting_time) begin
						$error("waiting_time: expected %0d, got %0d",
							want.waiting_time, waiting_time);
						bad++;
					end
					if (want.turnaround_time !== turnaround_time) begin
						$error("turnaround_time: expected %0d, got %0d",
							want.turnaround_time, turnaround_time);
						bad++;
					end
					if (want.all_done !== all_done) begin
						$error("all_done: expected %0d, got %0d",
							want.all_done, all_done);
						bad++;
					end
				end
			end
			if (bad != 0)
				n_errors <= n_errors + bad;

			// one long hold while the sender keeps going, then short bursts;
			// the hold starts with a second tick already taken so the
			// block backs up into its input
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				nx_stall = 1'b1;
			end else if (!hold_done && ticks_checked >= HOLD_AT &&
					ticks_predicted > ticks_checked + 1) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				nx_stall = 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				nx_stall = 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 6);
				nx_stall = 1'b1;
			end else begin
				nx_stall = 1'b0;
			end
			result_stall <= nx_stall;
		end
	end

	// ------------------------------------------------------------------
	// watchdog and end of run
	// ------------------------------------------------------------------

	// cycles with no transaction on either channel
	always @(posedge clk) begin : watchdog
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : finish_run
		do
			@(posedge clk);
		while (!(stim_done && ticks_checked == ticks_predicted));
		// late or extra results still get seen by the monitor
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_errors == 0 && expected_ticks.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/rrps_pkg.sv
sv/rrps_dp.sv
sv/rrps_ctrl.sv
sv/round_robin_process_scheduler.sv
bench/tb.sv
